// ===== sv/assert_macros.svh =====
// Assertion macros shared by the framed link RTL.
// Checks are compiled out when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted
`define FL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define FL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FL_ASSERT(label, prop, msg)
`define FL_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== sv/fl_pkg.sv =====
// Shared types, codes and sizes for the framed link with NACK resend.
// No dependencies; used by every module of the block.
`default_nettype none

package fl_pkg;

    // Frame size limits
    localparam int TX_FRAME_MAX = 8;
    localparam int RX_FRAME_MAX = 6;
    localparam int PAY_MAX      = (TX_FRAME_MAX - 4 < 4) ? TX_FRAME_MAX - 4 : 4;
    localparam int FRAME_BYTES  = PAY_MAX + 4;
    localparam int FIDX_W       = $clog2(FRAME_BYTES);
    localparam int FLEN_W       = $clog2(FRAME_BYTES + 1);
    localparam int RX_POS_W     = $clog2(RX_FRAME_MAX);
    localparam int RX_LEN_W     = $clog2(RX_FRAME_MAX + 1);
    localparam int MIN_RX_LEN   = 3;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reset values of the configuration registers
    localparam logic [7:0] START_RESET = 8'd2;
    localparam logic [7:0] END_RESET   = 8'd3;
    localparam logic [7:0] NACK_RESET  = 8'd21;
    localparam logic [2:0] RETRY_RESET = 3'd3;

    typedef enum logic [1:0] {
        OP_RX_BYTE = 2'd0,
        OP_SEND    = 2'd1,
        OP_TX_DONE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RK_BYTE    = 2'd0,
        RK_COMMAND = 2'd1,
        RK_RECEIVE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_START   = 2'd0,
        CFG_END     = 2'd1,
        CFG_NACK    = 2'd2,
        CFG_RETRIES = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] nack_code;
        logic [2:0] max_retries;
    } cfg_t;

    // One unit of work for the back end: a whole frame or a single result
    typedef struct packed {
        logic                             is_frame;
        logic [FRAME_BYTES-1:0][7:0]      frame;
        logic [FLEN_W-1:0]                frame_len;
        kind_t                            kind;
        logic [7:0]                       line_byte;
        logic [7:0]                       got_command;
        logic [7:0]                       got_data;
        logic                             drive;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ===== sv/fl_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on fl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fl_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire fl_pkg::job_t      push_job,
    input  wire logic              pop,
    output fl_pkg::job_t           head,
    output fl_pkg::q_status_t      status
);

    fl_pkg::job_t                  slot_reg [fl_pkg::QUEUE_DEPTH];
    logic [fl_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [fl_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [fl_pkg::QCNT_W-1:0]     count_reg, count_next;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == fl_pkg::QPTR_W'(fl_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + fl_pkg::QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == fl_pkg::QPTR_W'(fl_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + fl_pkg::QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + fl_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - fl_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == fl_pkg::QCNT_W'(fl_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    `FL_ASSERT(a_q_no_overflow, push |-> !status.full || pop, "job queue overflow")
    `FL_ASSERT(a_q_no_underflow, pop |-> !status.empty, "job queue underflow")

endmodule

`default_nettype wire

// ===== sv/fl_front.sv =====
// Front end: accepts input beats, deframes received bytes, builds and stores
// outgoing frames, tracks retries and line direction. Depends on fl_pkg.
`default_nettype none

module fl_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fl_pkg::cfg_t      cfg,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        operation,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [7:0]        tx_command,
    input  wire logic [2:0]        payload_count,
    input  wire logic [7:0]        payload_0,
    input  wire logic [7:0]        payload_1,
    input  wire logic [7:0]        payload_2,
    input  wire logic [7:0]        payload_3,
    input  wire fl_pkg::q_status_t q_status,
    output logic                   push,
    output fl_pkg::job_t           push_job
);

    // Receive deframer state
    logic [fl_pkg::RX_POS_W-1:0]   rx_pos_reg, rx_pos_next;
    logic [fl_pkg::RX_LEN_W-1:0]   rx_len_reg, rx_len_next;
    logic [7:0]                    rx_cmd_reg, rx_cmd_next;
    logic [7:0]                    rx_data_reg, rx_data_next;

    // Stored frame for resends
    logic [fl_pkg::FRAME_BYTES-1:0][7:0] stored_reg, stored_next;
    logic [fl_pkg::FLEN_W-1:0]     stored_len_reg, stored_len_next;
    logic [2:0]                    retry_reg, retry_next;
    logic                          dir_reg, dir_next;

    logic                          accept;
    logic [3:0][7:0]               payload;
    logic [2:0]                    n_clamp;
    logic [2:0]                    n_pay;
    logic [fl_pkg::FRAME_BYTES-1:0][7:0] built;
    logic [fl_pkg::RX_POS_W:0]     pos_plus1;
    logic                          len_ok;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign payload  = {payload_3, payload_2, payload_1, payload_0};

    // Payload count clamped to the frame size
    always_comb
    begin
        if (payload_count == 3'd0)
        begin
            n_clamp = 3'd1;
        end
        else if (payload_count > 3'd4)
        begin
            n_clamp = 3'd4;
        end
        else
        begin
            n_clamp = payload_count;
        end
        n_pay = (n_clamp > 3'(fl_pkg::PAY_MAX)) ? 3'(fl_pkg::PAY_MAX) : n_clamp;
    end

    // Outgoing frame: start, length, command, payload, end
    always_comb
    begin
        for (int k = 0; k < fl_pkg::FRAME_BYTES; k++)
        begin
            if (k == 0)
            begin
                built[k] = cfg.start_code;
            end
            else if (k == 1)
            begin
                built[k] = 8'(n_pay) + 8'd4;
            end
            else if (k == 2)
            begin
                built[k] = tx_command;
            end
            else if (k < 3 + int'(n_pay))
            begin
                built[k] = payload[2'(k - 3)];
            end
            else if (k == 3 + int'(n_pay))
            begin
                built[k] = cfg.end_code;
            end
            else
            begin
                built[k] = 8'h00;
            end
        end
    end

    assign pos_plus1 = {1'b0, rx_pos_reg} + (fl_pkg::RX_POS_W + 1)'(1);
    assign len_ok    = (rx_byte >= 8'(fl_pkg::MIN_RX_LEN))
                    && (rx_byte <= 8'(fl_pkg::RX_FRAME_MAX));

    // Classify the beat and build a job for the back end
    always_comb
    begin
        rx_pos_next     = rx_pos_reg;
        rx_len_next     = rx_len_reg;
        rx_cmd_next     = rx_cmd_reg;
        rx_data_next    = rx_data_reg;
        stored_next     = stored_reg;
        stored_len_next = stored_len_reg;
        retry_next      = retry_reg;
        dir_next        = dir_reg;
        push            = 1'b0;
        push_job        = '0;
        push_job.kind   = fl_pkg::RK_BYTE;

        if (accept)
        begin
            unique case (fl_pkg::op_t'(operation))
                fl_pkg::OP_RX_BYTE:
                begin
                    if (rx_pos_reg == '0)
                    begin
                        // Idle: frame start, stray byte or NACK
                        if (rx_byte == cfg.start_code)
                        begin
                            rx_pos_next  = fl_pkg::RX_POS_W'(1);
                            rx_cmd_next  = 8'h00;
                            rx_data_next = 8'h00;
                        end
                        else if (rx_byte != cfg.nack_code)
                        begin
                            retry_next = 3'd0;
                        end
                        if ((rx_byte == cfg.nack_code) && (stored_len_reg != '0)
                            && (retry_reg < cfg.max_retries))
                        begin
                            retry_next         = retry_reg + 3'd1;
                            dir_next           = 1'b1;
                            push               = 1'b1;
                            push_job.is_frame  = 1'b1;
                            push_job.frame     = stored_reg;
                            push_job.frame_len = stored_len_reg;
                        end
                    end
                    else if (rx_pos_reg == fl_pkg::RX_POS_W'(1))
                    begin
                        // Length byte
                        rx_len_next = fl_pkg::RX_LEN_W'(rx_byte);
                        rx_pos_next = len_ok ? fl_pkg::RX_POS_W'(2) : '0;
                    end
                    else
                    begin
                        if (rx_pos_reg == fl_pkg::RX_POS_W'(2))
                        begin
                            rx_cmd_next = rx_byte;
                        end
                        else if (rx_pos_reg == fl_pkg::RX_POS_W'(3))
                        begin
                            rx_data_next = rx_byte;
                        end
                        if ({1'b0, pos_plus1} >= (fl_pkg::RX_POS_W + 2)'(rx_len_reg))
                        begin
                            // End position: check the end byte
                            rx_pos_next = '0;
                            push        = 1'b1;
                            if (rx_byte == cfg.end_code)
                            begin
                                push_job.kind        = fl_pkg::RK_COMMAND;
                                push_job.got_command = rx_cmd_next;
                                push_job.got_data    = rx_data_next;
                                push_job.drive       = dir_reg;
                            end
                            else
                            begin
                                dir_next           = 1'b1;
                                push_job.kind      = fl_pkg::RK_BYTE;
                                push_job.line_byte = cfg.nack_code;
                                push_job.drive     = 1'b1;
                            end
                        end
                        else
                        begin
                            rx_pos_next = pos_plus1[fl_pkg::RX_POS_W-1:0];
                        end
                    end
                end
                fl_pkg::OP_SEND:
                begin
                    stored_next        = built;
                    stored_len_next    = fl_pkg::FLEN_W'(n_pay) + fl_pkg::FLEN_W'(4);
                    retry_next         = 3'd0;
                    dir_next           = 1'b1;
                    push               = 1'b1;
                    push_job.is_frame  = 1'b1;
                    push_job.frame     = built;
                    push_job.frame_len = stored_len_next;
                end
                fl_pkg::OP_TX_DONE:
                begin
                    dir_next       = 1'b0;
                    push           = 1'b1;
                    push_job.kind  = fl_pkg::RK_RECEIVE;
                    push_job.drive = 1'b0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_pos_reg     <= '0;
            rx_len_reg     <= '0;
            rx_cmd_reg     <= '0;
            rx_data_reg    <= '0;
            stored_len_reg <= '0;
            retry_reg      <= '0;
            dir_reg        <= 1'b0;
        end
        else
        begin
            rx_pos_reg     <= rx_pos_next;
            rx_len_reg     <= rx_len_next;
            rx_cmd_reg     <= rx_cmd_next;
            rx_data_reg    <= rx_data_next;
            stored_len_reg <= stored_len_next;
            retry_reg      <= retry_next;
            dir_reg        <= dir_next;
        end
    end

    // Stored frame bytes are undefined until the first send
    always_ff @(posedge clk)
    begin
        stored_reg <= stored_next;
    end

endmodule

`default_nettype wire

// ===== sv/fl_back.sv =====
// Back end: takes jobs from the queue and plays them out as result beats
// through an output register. Depends on fl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fl_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fl_pkg::job_t      head,
    input  wire fl_pkg::q_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             result_kind,
    output logic [7:0]             line_byte,
    output logic [7:0]             got_command,
    output logic [7:0]             got_data,
    output logic                   drive_transmit,
    output logic                   start_timeout,
    output logic                   last
);

    fl_pkg::job_t                  cur_reg, cur_next;
    logic                          busy_reg, busy_next;
    logic [fl_pkg::FIDX_W-1:0]     idx_reg, idx_next;

    logic                          ovalid_reg, ovalid_next;
    fl_pkg::kind_t                 kind_reg, kind_next;
    logic [7:0]                    byte_reg, byte_next;
    logic [7:0]                    cmd_reg, cmd_next;
    logic [7:0]                    data_reg, data_next;
    logic                          drive_reg, drive_next;
    logic                          tout_reg, tout_next;
    logic                          last_reg, last_next;

    logic                          can_load;
    logic                          frame_end;

    assign can_load  = !ovalid_reg || !out_stall;
    assign frame_end = ((fl_pkg::FLEN_W'(idx_reg) + fl_pkg::FLEN_W'(1)) == cur_reg.frame_len);

    // Play out the current job, fetch the next when done
    always_comb
    begin
        cur_next    = cur_reg;
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        pop         = 1'b0;
        ovalid_next = ovalid_reg;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        drive_next  = drive_reg;
        tout_next   = tout_reg;
        last_next   = last_reg;

        if (can_load)
        begin
            ovalid_next = 1'b0;
        end

        if (busy_reg && can_load)
        begin
            ovalid_next = 1'b1;
            if (cur_reg.is_frame)
            begin
                kind_next  = fl_pkg::RK_BYTE;
                byte_next  = cur_reg.frame[idx_reg];
                cmd_next   = 8'h00;
                data_next  = 8'h00;
                drive_next = 1'b1;
                tout_next  = frame_end;
                last_next  = frame_end;
                if (frame_end)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    idx_next = idx_reg + fl_pkg::FIDX_W'(1);
                end
            end
            else
            begin
                kind_next  = cur_reg.kind;
                byte_next  = cur_reg.line_byte;
                cmd_next   = cur_reg.got_command;
                data_next  = cur_reg.got_data;
                drive_next = cur_reg.drive;
                tout_next  = (cur_reg.kind == fl_pkg::RK_BYTE);
                last_next  = 1'b1;
                busy_next  = 1'b0;
            end
        end

        if (!busy_reg && !q_status.empty)
        begin
            pop       = 1'b1;
            cur_next  = head;
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Job and result payload
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        cmd_reg   <= cmd_next;
        data_reg  <= data_next;
        drive_reg <= drive_next;
        tout_reg  <= tout_next;
        last_reg  <= last_next;
    end

    assign out_valid      = ovalid_reg;
    assign result_kind    = kind_reg;
    assign line_byte      = byte_reg;
    assign got_command    = cmd_reg;
    assign got_data       = data_reg;
    assign drive_transmit = drive_reg;
    assign start_timeout  = tout_reg;
    assign last           = last_reg;

    `FL_ASSERT(a_tout_is_last, ovalid_reg && tout_reg |-> last_reg,
        "timeout start not on final beat")
    `FL_ASSERT(a_non_byte_single, ovalid_reg && (kind_reg != fl_pkg::RK_BYTE)
        |-> last_reg && !tout_reg, "non-byte result not a lone final beat")
    `FL_ASSERT(a_byte_drives, ovalid_reg && (kind_reg == fl_pkg::RK_BYTE) |-> drive_reg,
        "transmit byte with line in receive")

endmodule

`default_nettype wire

// ===== sv/framed_link_with_nack_retry.sv =====
// A result beat passes through the job queue, the back end's job register and
// the output register. A frame of L bytes (5..8) is played out at one byte per
// cycle unless the output stalls; a single result is one beat, and beats with
// no result push no job. A 2-deep job queue decouples input from output.
// Reset: all control state cleared, registers to defaults, no frame stored;
// the block is ready as soon as reset is released, with no clearing pass.
`default_nettype none

module framed_link_with_nack_retry (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  operation,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [7:0]  tx_command,
    input  wire logic [2:0]  payload_count,
    input  wire logic [7:0]  payload_0,
    input  wire logic [7:0]  payload_1,
    input  wire logic [7:0]  payload_2,
    input  wire logic [7:0]  payload_3,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       result_kind,
    output logic [7:0]       line_byte,
    output logic [7:0]       got_command,
    output logic [7:0]       got_data,
    output logic             drive_transmit,
    output logic             start_timeout,
    output logic             last
);

    fl_pkg::cfg_t            cfg_reg, cfg_next;
    fl_pkg::job_t            push_job;
    fl_pkg::job_t            head;
    fl_pkg::q_status_t       q_status;
    logic                    push;
    logic                    pop;

    assign cfg_ready = 1'b1;

    // Register file decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (fl_pkg::cfg_idx_t'(cfg_index))
                fl_pkg::CFG_START:   cfg_next.start_code  = cfg_data;
                fl_pkg::CFG_END:     cfg_next.end_code    = cfg_data;
                fl_pkg::CFG_NACK:    cfg_next.nack_code   = cfg_data;
                fl_pkg::CFG_RETRIES: cfg_next.max_retries = cfg_data[2:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code  <= fl_pkg::START_RESET;
            cfg_reg.end_code    <= fl_pkg::END_RESET;
            cfg_reg.nack_code   <= fl_pkg::NACK_RESET;
            cfg_reg.max_retries <= fl_pkg::RETRY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    fl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .rx_byte       (rx_byte),
        .tx_command    (tx_command),
        .payload_count (payload_count),
        .payload_0     (payload_0),
        .payload_1     (payload_1),
        .payload_2     (payload_2),
        .payload_3     (payload_3),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    fl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    fl_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_status       (q_status),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .line_byte      (line_byte),
        .got_command    (got_command),
        .got_data       (got_data),
        .drive_transmit (drive_transmit),
        .start_timeout  (start_timeout),
        .last           (last)
    );

endmodule

`default_nettype wire
